// ----- sv/multilevel_feedback_scheduler_core_macros.svh -----
// Assertion macros shared by the scheduler core RTL.
// Included by the files that carry concurrent checks; depends on nothing.
`ifndef MULTILEVEL_FEEDBACK_SCHEDULER_CORE_MACROS_SVH
`define MULTILEVEL_FEEDBACK_SCHEDULER_CORE_MACROS_SVH

// pre and post hold in the same cycle
`define MFS_ASSERT_SAME(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("scheduler check failed: same-cycle implication");

// post holds in the cycle after pre
`define MFS_ASSERT_NEXT(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("scheduler check failed: next-cycle implication");

`endif

// ----- sv/mfs_pkg.sv -----
// Shared types, codes and default sizes of the multilevel feedback scheduler.
// No dependencies; the interfaces, the execute stage, the core and the bench use it.
`timescale 1ns / 1ps

package mfs_pkg;

  localparam int unsigned LEVELS_DEF      = 5;
  localparam int unsigned LEVEL_DEPTH_DEF = 8;

  localparam int unsigned ID_W     = 8;
  localparam int unsigned LVL_W    = 3;
  localparam int unsigned BURST_W  = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned TIME_W   = 16;
  localparam int unsigned SLICE_W  = 8;
  localparam int unsigned WORD_W   = ID_W + BURST_W;

  localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd2;

  typedef enum logic {
    MODE_ADMIT    = 1'b0,
    MODE_DISPATCH = 1'b1
  } mfs_mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DEMOTED   = 3'd0,
    ST_COMPLETED = 3'd1,
    ST_IDLE      = 3'd2,
    ST_ADMITTED  = 3'd3,
    ST_REJECTED  = 3'd4,
    ST_DROPPED   = 3'd5
  } mfs_status_e;

  typedef struct packed {
    mfs_mode_e          mode;
    logic [ID_W-1:0]    task_id;
    logic [LVL_W-1:0]   start_level;
    logic [BURST_W-1:0] burst_units;
  } mfs_item_t;

  typedef struct packed {
    mfs_status_e        status;
    logic [ID_W-1:0]    served_id;
    logic [LVL_W-1:0]   served_level;
    logic [BURST_W-1:0] remaining_units;
    logic [TIME_W-1:0]  elapsed_time;
  } mfs_result_t;

endpackage

// ----- sv/mfs_if.sv -----
// Handshake channels of the scheduler: request items, result items, slice writes.
// Depends on mfs_pkg for field widths.
`timescale 1ns / 1ps

interface mfs_item_if;
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic [mfs_pkg::ID_W-1:0]     task_id;
  logic [mfs_pkg::LVL_W-1:0]    start_level;
  logic [mfs_pkg::BURST_W-1:0]  burst_units;

  modport source (output valid, mode, task_id, start_level, burst_units, input ready);
  modport sink   (input valid, mode, task_id, start_level, burst_units, output ready);
endinterface

interface mfs_result_if;
  logic                         valid;
  logic                         ready;
  logic [mfs_pkg::STATUS_W-1:0] status;
  logic [mfs_pkg::ID_W-1:0]     served_id;
  logic [mfs_pkg::LVL_W-1:0]    served_level;
  logic [mfs_pkg::BURST_W-1:0]  remaining_units;
  logic [mfs_pkg::TIME_W-1:0]   elapsed_time;

  modport source (output valid, status, served_id, served_level, remaining_units,
                  elapsed_time, input ready);
  modport sink   (input valid, status, served_id, served_level, remaining_units,
                  elapsed_time, output ready);
endinterface

interface mfs_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [mfs_pkg::SLICE_W-1:0]  data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- sv/mfs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mfs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 40
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/mfs_pick.sv -----
// Rotating priority pick: first nonempty level at or after the sweep pointer.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module mfs_pick #(
  parameter int unsigned LEVELS      = 5,
  parameter int unsigned LEVEL_DEPTH = 8
) (
  input  logic [LEVELS-1:0][$clog2(LEVEL_DEPTH+1)-1:0] counts_i,
  input  logic [$clog2(LEVELS)-1:0]                    sweep_i,
  output logic                                         found_o,
  output logic [$clog2(LEVELS)-1:0]                    level_o
);

  localparam int unsigned LIDX_W = $clog2(LEVELS);

  logic [LIDX_W:0]   probe;
  logic [LIDX_W-1:0] probe_lvl;

  always_comb begin
    found_o   = 1'b0;
    level_o   = '0;
    probe     = '0;
    probe_lvl = '0;
    for (int k = 0; k < LEVELS; k++) begin
      probe = (LIDX_W + 1)'(sweep_i) + (LIDX_W + 1)'(k);
      if (probe >= (LIDX_W + 1)'(LEVELS)) begin
        probe = probe - (LIDX_W + 1)'(LEVELS);
      end
      probe_lvl = probe[LIDX_W-1:0];
      if (!found_o && (counts_i[probe_lvl] != '0)) begin
        found_o = 1'b1;
        level_o = probe_lvl;
      end
    end
  end

endmodule

// ----- sv/mfs_exec.sv -----
// Execute stage: level FIFO bookkeeping, slice charging, demotion and result.
// Depends on mfs_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "multilevel_feedback_scheduler_core_macros.svh"

module mfs_exec #(
  parameter int unsigned LEVELS      = 5,
  parameter int unsigned LEVEL_DEPTH = 8
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          adv_i,
  input  mfs_pkg::mfs_item_t                            item_i,
  input  logic                                          found_i,
  input  logic [$clog2(LEVELS)-1:0]                     pick_lvl_i,
  input  logic [mfs_pkg::WORD_W-1:0]                    head_word_i,
  input  logic [mfs_pkg::SLICE_W-1:0]                   slice_i,
  output logic [LEVELS-1:0][$clog2(LEVEL_DEPTH+1)-1:0]  counts_d_o,
  output logic [LEVELS-1:0][$clog2(LEVEL_DEPTH)-1:0]    heads_d_o,
  output logic [$clog2(LEVELS)-1:0]                     sweep_d_o,
  output logic                                          we_o,
  output logic [$clog2(LEVELS*LEVEL_DEPTH)-1:0]         waddr_o,
  output logic [mfs_pkg::WORD_W-1:0]                    wdata_o,
  output mfs_pkg::mfs_result_t                          result_o
);

  import mfs_pkg::*;

  localparam int unsigned LIDX_W = $clog2(LEVELS);
  localparam int unsigned IDX_W  = $clog2(LEVEL_DEPTH);
  localparam int unsigned CNT_W  = $clog2(LEVEL_DEPTH + 1);
  localparam int unsigned ADDR_W = $clog2(LEVELS * LEVEL_DEPTH);
  localparam logic [LIDX_W-1:0] LAST_LVL = LIDX_W'(LEVELS - 1);
  localparam logic [ADDR_W-1:0] DEPTH_A  = ADDR_W'(LEVEL_DEPTH);

  logic [LEVELS-1:0][CNT_W-1:0] counts_q, counts_d;
  logic [LEVELS-1:0][IDX_W-1:0] heads_q, heads_d;
  logic [LIDX_W-1:0]            sweep_q, sweep_d;
  logic [TIME_W-1:0]            time_q, time_d;

  logic [LIDX_W-1:0]  adm_lvl;
  logic [LIDX_W-1:0]  push_lvl;
  logic [WORD_W-1:0]  push_word;
  logic               push_req;
  logic               push_ok;
  logic [IDX_W:0]     tail_sum;
  logic [ID_W-1:0]    head_id;
  logic [BURST_W-1:0] head_burst;
  logic [BURST_W-1:0] rem;

  // Out-of-range start levels land in the last level
  assign adm_lvl = (int'(item_i.start_level) >= LEVELS) ? LAST_LVL
                                                        : item_i.start_level[LIDX_W-1:0];
  assign head_id    = head_word_i[WORD_W-1 -: ID_W];
  assign head_burst = head_word_i[BURST_W-1:0];
  assign rem        = head_burst - slice_i;

  always_comb begin
    counts_d  = counts_q;
    heads_d   = heads_q;
    sweep_d   = sweep_q;
    time_d    = time_q;
    we_o      = 1'b0;
    waddr_o   = '0;
    wdata_o   = '0;
    push_req  = 1'b0;
    push_ok   = 1'b0;
    push_lvl  = '0;
    push_word = '0;
    tail_sum  = '0;
    result_o  = '{status: ST_IDLE, served_id: '0, served_level: '0,
                  remaining_units: '0, elapsed_time: time_q};
    if (adv_i) begin
      if (item_i.mode == MODE_ADMIT) begin
        push_req  = 1'b1;
        push_lvl  = adm_lvl;
        push_word = {item_i.task_id, item_i.burst_units};
        result_o.served_id       = item_i.task_id;
        result_o.served_level    = LVL_W'(adm_lvl);
        result_o.remaining_units = item_i.burst_units;
      end else if (found_i) begin
        // pop the head, charge one slice, advance the sweep
        heads_d[pick_lvl_i]  = (heads_q[pick_lvl_i] == IDX_W'(LEVEL_DEPTH - 1)) ? '0
                               : heads_q[pick_lvl_i] + IDX_W'(1);
        counts_d[pick_lvl_i] = counts_q[pick_lvl_i] - CNT_W'(1);
        time_d  = time_q + TIME_W'(slice_i);
        sweep_d = (pick_lvl_i == LAST_LVL) ? '0 : pick_lvl_i + LIDX_W'(1);
        result_o.served_id    = head_id;
        result_o.served_level = LVL_W'(pick_lvl_i);
        result_o.elapsed_time = time_d;
        if (head_burst <= slice_i) begin
          result_o.status = ST_COMPLETED;
        end else begin
          push_req  = 1'b1;
          push_lvl  = (pick_lvl_i == LAST_LVL) ? pick_lvl_i : pick_lvl_i + LIDX_W'(1);
          push_word = {head_id, rem};
          result_o.remaining_units = rem;
        end
      end
      // push onto the ring as it stands after any pop above
      if (push_req && (counts_d[push_lvl] < CNT_W'(LEVEL_DEPTH))) begin
        push_ok  = 1'b1;
        tail_sum = (IDX_W + 1)'(heads_d[push_lvl]) + (IDX_W + 1)'(counts_d[push_lvl]);
        if (tail_sum >= (IDX_W + 1)'(LEVEL_DEPTH)) begin
          tail_sum = tail_sum - (IDX_W + 1)'(LEVEL_DEPTH);
        end
        we_o    = 1'b1;
        waddr_o = ADDR_W'(push_lvl) * DEPTH_A + ADDR_W'(tail_sum[IDX_W-1:0]);
        wdata_o = push_word;
        counts_d[push_lvl] = counts_d[push_lvl] + CNT_W'(1);
      end
      if (item_i.mode == MODE_ADMIT) begin
        result_o.status = push_ok ? ST_ADMITTED : ST_REJECTED;
      end else if (found_i && push_req) begin
        result_o.status = push_ok ? ST_DEMOTED : ST_DROPPED;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counts_q <= '0;
      heads_q  <= '0;
      sweep_q  <= '0;
      time_q   <= '0;
    end else begin
      counts_q <= counts_d;
      heads_q  <= heads_d;
      sweep_q  <= sweep_d;
      time_q   <= time_d;
    end
  end

  assign counts_d_o = counts_d;
  assign heads_d_o  = heads_d;
  assign sweep_d_o  = sweep_d;

  `MFS_ASSERT_SAME(a_waddr_in_range, clk_i, rst_ni, we_o, int'(waddr_o) < LEVELS * LEVEL_DEPTH)
  `MFS_ASSERT_NEXT(a_idle_keeps_time, clk_i, rst_ni, adv_i && (item_i.mode == MODE_DISPATCH) && !found_i, $stable(time_q) && $stable(sweep_q))
  `MFS_ASSERT_SAME(a_write_only_on_advance, clk_i, rst_ni, !adv_i, !we_o && (counts_d == counts_q))

endmodule

// ----- sv/multilevel_feedback_scheduler_core.sv -----
// Multilevel feedback scheduler: one request item in, one result item out.
// Channels: in_i (admit a task or request a dispatch), out_o (one result per
// item), cfg_i (time slice writes, always ready; write only with no item in flight).
// An accepted item picks its level and reads the head task from the entry
// RAM at the accept edge, waits in the input register until the output
// register can take its result, is then executed against the level FIFO
// counters, and its result lands in the output register.
// Throughput is one item per cycle while out_o does not stall; the loop that
// sets it is the combinational path from the head word and the level counters
// through the level pick to the next entry RAM read address.
// Reset empties all level FIFOs, zeroes elapsed time and the sweep pointer
// and sets the slice to 2; the entry RAM itself is not cleared.
// When out_o stalls, the output register holds its result, the item in the
// execute stage waits behind it and in_i drops ready; nothing is lost.
// Depends on mfs_pkg, mfs_if, mfs_ram, mfs_pick, mfs_exec and the macros header.
`timescale 1ns / 1ps
`include "multilevel_feedback_scheduler_core_macros.svh"

module multilevel_feedback_scheduler_core #(
  parameter int unsigned LEVELS      = mfs_pkg::LEVELS_DEF,
  parameter int unsigned LEVEL_DEPTH = mfs_pkg::LEVEL_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mfs_item_if.sink   in_i,
  mfs_result_if.source out_o,
  mfs_cfg_if.sink    cfg_i
);

  import mfs_pkg::*;

  localparam int unsigned LIDX_W = $clog2(LEVELS);
  localparam int unsigned IDX_W  = $clog2(LEVEL_DEPTH);
  localparam int unsigned CNT_W  = $clog2(LEVEL_DEPTH + 1);
  localparam int unsigned ADDR_W = $clog2(LEVELS * LEVEL_DEPTH);
  localparam logic [ADDR_W-1:0] DEPTH_A = ADDR_W'(LEVEL_DEPTH);

  logic [SLICE_W-1:0] slice_q;

  logic        accept;
  logic        s1_adv;
  logic        s1_valid_q;
  mfs_item_t   s1_item_q;
  logic        s1_found_q;
  logic [LIDX_W-1:0] s1_lvl_q;
  logic        fwd_hit_q;
  logic [WORD_W-1:0] fwd_data_q;

  logic        out_valid_q;
  mfs_result_t out_q;

  mfs_item_t   in_item;
  logic [LEVELS-1:0][CNT_W-1:0] counts_d;
  logic [LEVELS-1:0][IDX_W-1:0] heads_d;
  logic [LIDX_W-1:0] sweep_d;
  logic              pick_found;
  logic [LIDX_W-1:0] pick_lvl;
  logic [ADDR_W-1:0] raddr;
  logic [WORD_W-1:0] ram_rdata;
  logic [WORD_W-1:0] head_word;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [WORD_W-1:0] wdata;
  mfs_result_t       exec_result;

  assign in_item = '{mode: mfs_mode_e'(in_i.mode), task_id: in_i.task_id,
                     start_level: in_i.start_level, burst_units: in_i.burst_units};

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign accept     = in_i.valid && in_i.ready;

  // slice register
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_q <= SLICE_RESET;
    end else if (cfg_i.valid) begin
      slice_q <= cfg_i.data;
    end
  end

  // pick against the state as left by the item now executing
  mfs_pick #(
    .LEVELS      (LEVELS),
    .LEVEL_DEPTH (LEVEL_DEPTH)
  ) u_pick (
    .counts_i (counts_d),
    .sweep_i  (sweep_d),
    .found_o  (pick_found),
    .level_o  (pick_lvl)
  );

  assign raddr = ADDR_W'(pick_lvl) * DEPTH_A + ADDR_W'(heads_d[pick_lvl]);

  mfs_ram #(
    .WIDTH (WORD_W),
    .DEPTH (LEVELS * LEVEL_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (accept),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  // input register; capture a bypass when the read hits this cycle's write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
      fwd_hit_q  <= we && (waddr == raddr);
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q  <= in_item;
      s1_found_q <= pick_found;
      s1_lvl_q   <= pick_lvl;
      fwd_data_q <= wdata;
    end
  end

  assign head_word = fwd_hit_q ? fwd_data_q : ram_rdata;

  mfs_exec #(
    .LEVELS      (LEVELS),
    .LEVEL_DEPTH (LEVEL_DEPTH)
  ) u_exec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (s1_adv),
    .item_i      (s1_item_q),
    .found_i     (s1_found_q),
    .pick_lvl_i  (s1_lvl_q),
    .head_word_i (head_word),
    .slice_i     (slice_q),
    .counts_d_o  (counts_d),
    .heads_d_o   (heads_d),
    .sweep_d_o   (sweep_d),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .result_o    (exec_result)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q <= exec_result;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.status          = out_q.status;
  assign out_o.served_id       = out_q.served_id;
  assign out_o.served_level    = out_q.served_level;
  assign out_o.remaining_units = out_q.remaining_units;
  assign out_o.elapsed_time    = out_q.elapsed_time;

  `MFS_ASSERT_NEXT(a_advance_fills_output, clk_i, rst_ni, s1_adv, out_valid_q)
  `MFS_ASSERT_NEXT(a_accept_fills_stage, clk_i, rst_ni, accept, s1_valid_q)
  `MFS_ASSERT_SAME(a_bypass_needs_item, clk_i, rst_ni, fwd_hit_q, s1_valid_q)

endmodule

// ----- verif/tb_top.sv -----
// Self-checking bench for multilevel_feedback_scheduler_core: drives admit and
// dispatch items, predicts each result in SV and checks it on the result port.
// Depends on mfs_pkg, mfs_if and the scheduler core RTL.
`timescale 1ns / 1ps

module tb_top;
  import mfs_pkg::*;

  localparam int unsigned LEVELS      = LEVELS_DEF;
  localparam int unsigned LEVEL_DEPTH = LEVEL_DEPTH_DEF;

  logic clk_i = 1'b0;
  logic rst_ni;

  mfs_item_if   req_if ();
  mfs_result_if res_if ();
  mfs_cfg_if    slice_if ();

  multilevel_feedback_scheduler_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (res_if),
    .cfg_i  (slice_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Scheduler shadow state
  logic [WORD_W-1:0]  task_ram [LEVELS][LEVEL_DEPTH];
  int unsigned        ring_head [LEVELS];
  int unsigned        ring_fill [LEVELS];
  int unsigned        sweep_lvl;
  logic [TIME_W-1:0]  elapsed_units;
  logic [SLICE_W-1:0] slice_units;

  mfs_item_t   queued_requests [$];
  mfs_result_t due_results [$];
  mfs_item_t   req_now;
  int          mismatches = 0;
  int          in_gap_pct = 0;
  int          out_gap_pct = 0;
  int          in_hold = 0;
  int          out_hold = 0;

  function automatic bit push_task(int unsigned lvl, logic [WORD_W-1:0] word);
    if (ring_fill[lvl] >= LEVEL_DEPTH) return 1'b0;
    task_ram[lvl][(ring_head[lvl] + ring_fill[lvl]) % LEVEL_DEPTH] = word;
    ring_fill[lvl]++;
    return 1'b1;
  endfunction

  function automatic mfs_result_t schedule_step(mfs_item_t it);
    mfs_result_t        r;
    int unsigned        lvl;
    int unsigned        pick;
    bit                 found;
    logic [WORD_W-1:0]  word;
    logic [BURST_W-1:0] rem;
    r = '0;
    r.status = ST_IDLE;
    if (it.mode == MODE_ADMIT) begin
      lvl = (it.start_level >= LEVELS) ? LEVELS - 1 : it.start_level;
      r.status = push_task(lvl, {it.task_id, it.burst_units}) ? ST_ADMITTED : ST_REJECTED;
      r.served_id       = it.task_id;
      r.served_level    = LVL_W'(lvl);
      r.remaining_units = it.burst_units;
      r.elapsed_time    = elapsed_units;
      return r;
    end
    found = 1'b0;
    pick = 0;
    for (int k = 0; k < LEVELS && !found; k++) begin
      pick = (sweep_lvl + k) % LEVELS;
      if (ring_fill[pick] != 0) found = 1'b1;
    end
    if (!found) begin
      r.elapsed_time = elapsed_units;
      return r;
    end
    word = task_ram[pick][ring_head[pick]];
    ring_head[pick] = (ring_head[pick] + 1) % LEVEL_DEPTH;
    ring_fill[pick]--;
    elapsed_units = elapsed_units + slice_units;
    sweep_lvl = (pick + 1 >= LEVELS) ? 0 : pick + 1;
    if (word[BURST_W-1:0] <= slice_units) begin
      rem = '0;
      r.status = ST_COMPLETED;
    end else begin
      rem = word[BURST_W-1:0] - slice_units;
      // last level recycles its own tasks
      lvl = (pick + 1 >= LEVELS) ? pick : pick + 1;
      r.status = push_task(lvl, {word[WORD_W-1:BURST_W], rem}) ? ST_DEMOTED : ST_DROPPED;
    end
    r.served_id       = word[WORD_W-1:BURST_W];
    r.served_level    = LVL_W'(pick);
    r.remaining_units = rem;
    r.elapsed_time    = elapsed_units;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Request driver: hold the item until accepted, then advance or idle
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        due_results.push_back(schedule_step(req_now));
      end
      if (!req_if.valid || req_if.ready) begin
        if (in_hold > 0) begin
          in_hold--;
          req_if.valid <= 1'b0;
        end else if (queued_requests.size() != 0 && $urandom_range(99) < in_gap_pct) begin
          in_hold = $urandom_range(6, 1) - 1;
          req_if.valid <= 1'b0;
        end else if (queued_requests.size() != 0) begin
          req_now = queued_requests.pop_front();
          req_if.valid       <= 1'b1;
          req_if.mode        <= req_now.mode;
          req_if.task_id     <= req_now.task_id;
          req_if.start_level <= req_now.start_level;
          req_if.burst_units <= req_now.burst_units;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result sink: random stall bursts
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else if (out_hold > 0) begin
      out_hold--;
      res_if.ready <= 1'b0;
    end else if ($urandom_range(99) < out_gap_pct) begin
      out_hold = $urandom_range(6, 1) - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    mfs_result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (due_results.size() == 0) begin
        report_mismatch("unexpected result, status", res_if.status, -1);
      end else begin
        want = due_results.pop_front();
        if (res_if.status !== want.status)
          report_mismatch("status", res_if.status, want.status);
        if (res_if.served_id !== want.served_id)
          report_mismatch("served_id", res_if.served_id, want.served_id);
        if (res_if.served_level !== want.served_level)
          report_mismatch("served_level", res_if.served_level, want.served_level);
        if (res_if.remaining_units !== want.remaining_units)
          report_mismatch("remaining_units", res_if.remaining_units, want.remaining_units);
        if (res_if.elapsed_time !== want.elapsed_time)
          report_mismatch("elapsed_time", res_if.elapsed_time, want.elapsed_time);
      end
    end
  end

  task automatic add_request(mfs_mode_e mode, int id, int lvl, int burst);
    mfs_item_t it;
    it.mode        = mode;
    it.task_id     = ID_W'(id);
    it.start_level = LVL_W'(lvl);
    it.burst_units = BURST_W'(burst);
    queued_requests.push_back(it);
  endtask

  task automatic add_random(int count, int admit_pct);
    int burst_cap;
    int burst;
    burst_cap = 3 * slice_units + 4;
    if (burst_cap > 255) burst_cap = 255;
    repeat (count) begin
      if ($urandom_range(99) < admit_pct) begin
        case ($urandom_range(7))
          0:       burst = 0;
          1:       burst = 255;
          default: burst = $urandom_range(burst_cap, 0);
        endcase
        add_request(MODE_ADMIT, $urandom_range(255),
                    ($urandom_range(4) == 0) ? $urandom_range(7, 5) : $urandom_range(4),
                    burst);
      end else begin
        add_request(MODE_DISPATCH, $urandom_range(255), $urandom_range(7),
                    $urandom_range(255));
      end
    end
  endtask

  task automatic wait_drained();
    int n;
    n = 0;
    while ((queued_requests.size() != 0 || req_if.valid || due_results.size() != 0)
           && n < 50000) begin
      @(posedge clk_i);
      n++;
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_slice(logic [SLICE_W-1:0] value);
    wait_drained();
    slice_if.valid <= 1'b1;
    slice_if.data  <= value;
    do @(posedge clk_i); while (!slice_if.ready);
    slice_if.valid <= 1'b0;
    slice_units = value;
  endtask

  initial begin
    rst_ni = 1'b0;
    req_if.valid       = 1'b0;
    req_if.mode        = MODE_ADMIT;
    req_if.task_id     = '0;
    req_if.start_level = '0;
    req_if.burst_units = '0;
    res_if.ready       = 1'b0;
    slice_if.valid     = 1'b0;
    slice_if.data      = '0;
    for (int l = 0; l < LEVELS; l++) begin
      ring_head[l] = 0;
      ring_fill[l] = 0;
    end
    sweep_lvl     = 0;
    elapsed_units = '0;
    slice_units   = SLICE_RESET;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset slice
    in_gap_pct  = 20;
    out_gap_pct = 20;
    add_request(MODE_DISPATCH, 0, 0, 0);            // nothing queued
    add_request(MODE_ADMIT, 8'hFF, 0, 0);           // zero burst
    add_request(MODE_ADMIT, 8'h00, 7, 8'hFF);       // level saturates to the last
    add_request(MODE_ADMIT, 8'h5A, 5, 3);
    add_request(MODE_ADMIT, 8'hA5, 6, 4);
    add_request(MODE_ADMIT, 8'h81, 2, 200);
    for (int i = 0; i < LEVEL_DEPTH + 1; i++)       // last one hits a full ring
      add_request(MODE_ADMIT, 8'h30 + i, 3, (i % 2) ? 8'hAA : 8'h55);
    add_request(MODE_DISPATCH, 0, 0, 0);            // completes zero burst
    add_request(MODE_DISPATCH, 0, 0, 0);            // demotion into full level 3
    add_request(MODE_DISPATCH, 0, 0, 0);            // level 3 into level 4
    add_request(MODE_DISPATCH, 0, 0, 0);            // last level keeps its task
    add_request(MODE_DISPATCH, 8'hFF, 7, 8'hFF);

    write_slice(8'd1);
    in_gap_pct  = 30;
    out_gap_pct = 30;
    add_random(220, 50);

    write_slice(8'd255);
    in_gap_pct  = 0;
    out_gap_pct = 40;
    add_random(220, 60);

    // zero slice: nothing ever progresses except zero-burst tasks
    write_slice(8'd0);
    in_gap_pct  = 40;
    out_gap_pct = 0;
    add_random(140, 40);

    write_slice(SLICE_W'($urandom_range(30, 3)));
    in_gap_pct  = 20;
    out_gap_pct = 20;
    add_random(220, 70);

    write_slice(SLICE_W'($urandom_range(255, 1)));
    in_gap_pct  = 35;
    out_gap_pct = 15;
    add_random(220, 45);

    // final stretch at full rate on both sides
    write_slice(8'd2);
    in_gap_pct  = 0;
    out_gap_pct = 0;
    add_random(200, 55);

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (due_results.size() != 0)
      report_mismatch("results never delivered", 0, due_results.size());
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    #400000;
    $display("FAIL");
    $finish;
  end

endmodule
